@@ src/b2r_pkg.sv @@
// ----------------------------------------------------------------------------
// b2r_pkg
// Shared constants, types and digit pattern lookup for the Roman numeral core.
// ----------------------------------------------------------------------------
package b2r_pkg;

	localparam int MaxValue   = 3999;
	localparam int MaxLetters = 15;
	localparam int LenW       = $clog2(MaxLetters + 1);
	localparam int BufW       = MaxLetters * 8;

	localparam logic [7:0] ChI = 8'h49;
	localparam logic [7:0] ChV = 8'h56;
	localparam logic [7:0] ChX = 8'h58;
	localparam logic [7:0] ChL = 8'h4C;
	localparam logic [7:0] ChC = 8'h43;
	localparam logic [7:0] ChD = 8'h44;
	localparam logic [7:0] ChM = 8'h4D;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  len;
	} pat_t;

	typedef struct packed {
		logic [BufW-1:0] letters;
		logic [LenW-1:0] len;
		logic            empty_res;
		logic            out_of_range;
	} dec_t;

	// first letter in the low byte
	function automatic pat_t digit_pat(input logic [3:0] d, input logic [7:0] one,
			input logic [7:0] five, input logic [7:0] ten);
		pat_t p;
		p.word = '0;
		p.len  = '0;
		case (d)
			4'd1: begin
				p.word = {24'h0, one};
				p.len  = 3'd1;
			end
			4'd2: begin
				p.word = {16'h0, one, one};
				p.len  = 3'd2;
			end
			4'd3: begin
				p.word = {8'h0, one, one, one};
				p.len  = 3'd3;
			end
			4'd4: begin
				p.word = {16'h0, five, one};
				p.len  = 3'd2;
			end
			4'd5: begin
				p.word = {24'h0, five};
				p.len  = 3'd1;
			end
			4'd6: begin
				p.word = {16'h0, one, five};
				p.len  = 3'd2;
			end
			4'd7: begin
				p.word = {8'h0, one, one, five};
				p.len  = 3'd3;
			end
			4'd8: begin
				p.word = {one, one, one, five};
				p.len  = 3'd4;
			end
			4'd9: begin
				p.word = {16'h0, ten, one};
				p.len  = 3'd2;
			end
			default: begin
				p.word = '0;
				p.len  = '0;
			end
		endcase
		return p;
	endfunction

endpackage

@@ src/binary_to_roman_numeral_core.sv @@
// ----------------------------------------------------------------------------
// binary_to_roman_numeral_core
// Converts an unsigned value to its subtractive Roman numeral, one letter per
// output transfer, with a last flag on the final letter.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    value[15:0]
//   out      source     out_valid / out_ready  symbol[7:0], last, empty_res,
//                                              out_of_range
//
// An accepted value is held in the input register, where it is decoded, until
// it moves to the result register. Each value occupies the output for as many
// transfers as it has letters (1 to 15); zero and out-of-range values take
// one. The input register refills while the result register still drains.
// Reset clears both valid flags; a stalled output holds the current letter.
// ----------------------------------------------------------------------------
module binary_to_roman_numeral_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  symbol,
	output logic        last,
	output logic        empty_res,
	output logic        out_of_range
);

	logic          vld_s1;
	logic [15:0]   value_s1;
	logic          load_ready;
	b2r_pkg::dec_t dec;

	assign in_ready = !vld_s1 || load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			value_s1 <= value;
		end
	end

	b2r_decode u_decode (
		.value (value_s1),
		.dec   (dec)
	);

	b2r_serialiser u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (vld_s1),
		.dec          (dec),
		.load_ready   (load_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.symbol       (symbol),
		.last         (last),
		.empty_res    (empty_res),
		.out_of_range (out_of_range)
	);

`ifndef SYNTHESIS
	a_flag_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (empty_res || out_of_range)) |-> last)
		else $error("flagged result not marked last");

	a_flag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(empty_res && out_of_range))
		else $error("empty and out of range both set");

	a_letter_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !empty_res && !out_of_range) |-> (symbol != 8'h00))
		else $error("letter result with null symbol");

	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> out_valid)
		else $error("numeral run broken before last letter");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !load_ready) |=> vld_s1)
		else $error("input register dropped a value");
`endif

endmodule

@@ src/b2r_decode.sv @@
// ----------------------------------------------------------------------------
// b2r_decode
// Splits a value into decimal digits and packs its numeral into a letter word.
// ----------------------------------------------------------------------------
module b2r_decode (
	input  logic [15:0]   value,
	output b2r_pkg::dec_t dec
);

	logic [13:0] v14;
	logic [27:0] prod_th;
	logic [26:0] prod_hq;
	logic [26:0] prod_tq;
	logic [3:0]  th;
	logic [6:0]  hq;
	logic [9:0]  tq;
	logic [6:0]  th_x10;
	logic [9:0]  hq_x10;
	logic [13:0] tq_x10;
	logic [3:0]  dh;
	logic [3:0]  dt;
	logic [3:0]  du;
	b2r_pkg::pat_t ph;
	b2r_pkg::pat_t pt;
	b2r_pkg::pat_t pu;
	logic [4:0]  off_h;
	logic [4:0]  off_t;
	logic [4:0]  off_u;
	logic [4:0]  total;
	logic [b2r_pkg::BufW-1:0] m_run;
	logic [b2r_pkg::BufW-1:0] word;
	logic        is_zero;
	logic        too_big;

	assign v14 = value[13:0];

	// reciprocal multiplies, exact for values up to 9999
	assign prod_th = 28'(v14) * 28'd8389;
	assign prod_hq = 27'(v14) * 27'd5243;
	assign prod_tq = 27'(v14) * 27'd6554;
	assign th = prod_th[26:23];
	assign hq = prod_hq[25:19];
	assign tq = prod_tq[25:16];

	assign th_x10 = 7'({th, 3'b000}) + 7'({th, 1'b0});
	assign hq_x10 = 10'({hq, 3'b000}) + 10'({hq, 1'b0});
	assign tq_x10 = 14'({tq, 3'b000}) + 14'({tq, 1'b0});
	assign dh = 4'(hq - th_x10);
	assign dt = 4'(tq - hq_x10);
	assign du = 4'(v14 - tq_x10);

	assign ph = b2r_pkg::digit_pat(dh, b2r_pkg::ChC, b2r_pkg::ChD, b2r_pkg::ChM);
	assign pt = b2r_pkg::digit_pat(dt, b2r_pkg::ChX, b2r_pkg::ChL, b2r_pkg::ChC);
	assign pu = b2r_pkg::digit_pat(du, b2r_pkg::ChI, b2r_pkg::ChV, b2r_pkg::ChX);

	assign off_h = 5'(th);
	assign off_t = off_h + 5'(ph.len);
	assign off_u = off_t + 5'(pt.len);
	assign total = off_u + 5'(pu.len);

	always_comb begin
		for (int i = 0; i < b2r_pkg::MaxLetters; i++) begin
			m_run[i*8 +: 8] = (4'(i) < th) ? b2r_pkg::ChM : 8'h00;
		end
	end

	assign word = m_run
		| (b2r_pkg::BufW'(ph.word) << {off_h, 3'b000})
		| (b2r_pkg::BufW'(pt.word) << {off_t, 3'b000})
		| (b2r_pkg::BufW'(pu.word) << {off_u, 3'b000});

	assign is_zero = (value == 16'd0);
	assign too_big = (value > 16'(b2r_pkg::MaxValue)) || (total > 5'(b2r_pkg::MaxLetters));

	always_comb begin
		dec.empty_res    = is_zero;
		dec.out_of_range = !is_zero && too_big;
		if (is_zero || too_big) begin
			dec.letters = '0;
			dec.len     = b2r_pkg::LenW'(1);
		end else begin
			dec.letters = word;
			dec.len     = b2r_pkg::LenW'(total);
		end
	end

endmodule

@@ src/b2r_serialiser.sv @@
// ----------------------------------------------------------------------------
// b2r_serialiser
// Result register that shifts out one letter per transfer.
// ----------------------------------------------------------------------------
module b2r_serialiser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load_valid,
	input  b2r_pkg::dec_t dec,
	output logic          load_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    symbol,
	output logic          last,
	output logic          empty_res,
	output logic          out_of_range
);

	logic                      valid_q;
	logic [b2r_pkg::LenW-1:0]  cnt_q;
	logic [b2r_pkg::BufW-1:0]  buf_q;
	logic                      empty_q;
	logic                      oor_q;
	logic                      take;
	logic                      fin;

	assign take       = valid_q && out_ready;
	assign last       = (cnt_q == b2r_pkg::LenW'(1));
	assign fin        = !valid_q || (take && last);
	assign load_ready = fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= b2r_pkg::LenW'(1);
		end else if (fin) begin
			valid_q <= load_valid;
			if (load_valid) begin
				cnt_q <= dec.len;
			end
		end else if (take) begin
			cnt_q <= cnt_q - b2r_pkg::LenW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (fin && load_valid) begin
			buf_q   <= dec.letters;
			empty_q <= dec.empty_res;
			oor_q   <= dec.out_of_range;
		end else if (take) begin
			buf_q <= buf_q >> 8;
		end
	end

	assign out_valid    = valid_q;
	assign symbol       = buf_q[7:0];
	assign empty_res    = empty_q;
	assign out_of_range = oor_q;

endmodule
